[rtl/bcrc_pkg.sv]
// Shared types and constants for the button click repeat counter.
// No dependencies; imported by bcrc_step and button_click_repeat_counter.
package bcrc_pkg;

    localparam int unsigned INTERVAL_W = 14;
    localparam int unsigned SLEEP_W    = 20;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned COUNT_W    = 8;
    localparam int unsigned CFG_IDX_W  = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_INTERVAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_TIMEOUT = 1'd1;

    // Configuration reset values
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 14'd100;
    localparam logic [SLEEP_W-1:0]    SLEEP_RESET    = 20'd30000;

    // Extra milliseconds a hold must exceed beyond one interval before release counts
    localparam logic [INTERVAL_W:0]   RELEASE_MARGIN = 15'd2;

    // Persistent counter state
    typedef struct packed {
        logic                held;
        logic [TIME_W-1:0]   press_time;
        logic [TIME_W-1:0]   last_activity_time;
        logic [COUNT_W-1:0]  counter_value;
    } t_state;

    // Active configuration
    typedef struct packed {
        logic [INTERVAL_W-1:0] loop_interval_ms;
        logic [SLEEP_W-1:0]    sleep_timeout_ms;
    } t_cfg;

endpackage

[rtl/bcrc_step.sv]
// Per-sample decision logic: release, wake, bounce, new hold and auto-repeat.
// Purely combinational; uses bcrc_pkg types.
module bcrc_step (
    input  bcrc_pkg::t_cfg                       i_cfg,
    input  bcrc_pkg::t_state                     i_state,
    input  logic                                 i_level,
    input  logic [bcrc_pkg::TIME_W-1:0]          i_now,
    output bcrc_pkg::t_state                     o_state,
    output logic                                 o_inc
);
    import bcrc_pkg::*;

    logic [TIME_W-1:0]     act_diff;
    logic [TIME_W-1:0]     hold_diff;
    logic signed [TIME_W:0] act_s;
    logic signed [TIME_W:0] hold_s;
    logic [INTERVAL_W:0]   thr_release;
    logic [INTERVAL_W:0]   thr_bounce;
    logic [INTERVAL_W+2:0] thr_repeat;
    logic                  is_wake;
    logic                  is_bounce;
    logic                  hold_past_release;
    logic                  hold_past_repeat;

    // Wrapping time differences, read as signed
    assign act_diff  = i_now - i_state.last_activity_time;
    assign hold_diff = i_now - i_state.press_time;
    assign act_s     = $signed({act_diff[TIME_W-1], act_diff});
    assign hold_s    = $signed({hold_diff[TIME_W-1], hold_diff});

    // Thresholds scaled by the interval (shift-and-add)
    assign thr_release = {1'b0, i_cfg.loop_interval_ms} + RELEASE_MARGIN;
    assign thr_bounce  = {i_cfg.loop_interval_ms, 1'b0};
    assign thr_repeat  = {1'b0, i_cfg.loop_interval_ms, 2'b00}
                       + {3'b000, i_cfg.loop_interval_ms};

    // Compares, all against non-negative thresholds
    assign is_wake   = act_s > $signed({{(TIME_W-SLEEP_W+1){1'b0}}, i_cfg.sleep_timeout_ms});
    assign is_bounce = act_s < $signed({{(TIME_W-INTERVAL_W){1'b0}}, thr_bounce});
    assign hold_past_release =
        hold_s > $signed({{(TIME_W-INTERVAL_W){1'b0}}, thr_release});
    assign hold_past_repeat  =
        hold_s > $signed({{(TIME_W-INTERVAL_W-2){1'b0}}, thr_repeat});

    // Next state
    always_comb begin
        o_state = i_state;
        o_inc   = 1'b0;
        if (!i_level) begin
            if (i_state.held && hold_past_release) begin
                o_state.held = 1'b0;
                o_inc        = 1'b1;
            end
        end else if (is_wake) begin
            o_state.last_activity_time = i_now;
        end else if (is_bounce) begin
            o_state = i_state;
        end else if (!i_state.held) begin
            o_state.held               = 1'b1;
            o_state.press_time         = i_now;
            o_state.last_activity_time = i_now;
        end else if (hold_past_repeat) begin
            o_inc                      = 1'b1;
            o_state.last_activity_time = i_now;
        end
        if (o_inc) begin
            o_state.counter_value = i_state.counter_value + 8'd1;
        end
    end

endmodule

[rtl/button_click_repeat_counter.sv]
// Top level of the button click repeat counter: stream ports, sample and result registers.
// Depends on bcrc_pkg and bcrc_step.
//
// Each request on the slave stream is one button sample (level and a free-running
// millisecond time) and yields exactly one result on the master stream: the 8-bit
// counter value after that sample and a flag set when the sample counted. One sample
// is accepted per clock unless the master stream stalls. A taken sample first sits in the
// sample register; the decision and state update happen on its move into the result
// register, from which the result is offered. While a result waits, the sample register takes
// one more request and then holds the slave stream off until the result is taken.
// The two configuration registers are written through i_cfg_we/i_cfg_index/i_cfg_data
// and must only be changed while no sample is in flight.
module button_click_repeat_counter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream: [0] button_level, [32:1] now_ms, [39:33] zero
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    // master stream: [7:0] message_value, [8] changed, [15:9] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [bcrc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bcrc_pkg::SLEEP_W-1:0]    i_cfg_data
);
    import bcrc_pkg::*;

    logic              r_in_valid;
    logic              r_in_level;
    logic [TIME_W-1:0] r_in_now;
    logic              r_out_valid;
    logic [COUNT_W-1:0] r_out_value;
    logic              r_out_changed;
    t_state            r_state;
    t_state            n_state;
    t_cfg              r_cfg;
    logic              step_inc;
    logic              out_free;
    logic              advance;

    // Handshake control
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || advance;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.loop_interval_ms <= INTERVAL_RESET;
            r_cfg.sleep_timeout_ms <= SLEEP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LOOP_INTERVAL: r_cfg.loop_interval_ms <= i_cfg_data[INTERVAL_W-1:0];
                CFG_SLEEP_TIMEOUT: r_cfg.sleep_timeout_ms <= i_cfg_data;
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    // Sample register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_level <= s_axis_tdata[0];
            r_in_now   <= s_axis_tdata[TIME_W:1];
        end
    end

    // Decision logic
    bcrc_step u_step (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_level (r_in_level),
        .i_now   (r_in_now),
        .o_state (n_state),
        .o_inc   (step_inc)
    );

    // Counter state, updated as a sample moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_value   <= n_state.counter_value;
            r_out_changed <= step_inc;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_changed, r_out_value};

endmodule
